// ----- src/irlps_pkg.sv -----
`timescale 1ns / 1ps

package irlps_pkg;

    localparam int FRAME_BYTES_DEF = 4;

    localparam int CFG_W     = 8;
    localparam int CFG_IDX_W = 3;
    localparam int BIT_CNT_W = 6;

    localparam logic [7:0] INTERVAL_STEP  = 8'd50;
    localparam logic [7:0] INTERVAL_LIMIT = 8'd201;
    localparam logic [7:0] INTERVAL_RESET = 8'd50;
    localparam logic [2:0] LED_OFF        = 3'd7;

    localparam logic [7:0] LEADER_MIN_RST   = 8'h3E;
    localparam logic [7:0] LEADER_MAX_RST   = 8'h4E;
    localparam logic [7:0] ONE_THRESH_RST   = 8'h08;
    localparam logic [7:0] END_GAP_RST      = 8'h10;
    localparam logic [7:0] CMD_NEXT_RST     = 8'h02;
    localparam logic [7:0] CMD_SLOWER_RST   = 8'h04;
    localparam logic [7:0] CMD_FASTER_RST   = 8'h0C;

    localparam logic [3:0] PAT_LEN [0:2] = '{4'd6, 4'd14, 4'd12};

    localparam logic [2:0] PAT_TAB [0:2][0:15] = '{
        '{3'd4, 3'd0, 3'd2, 3'd0, 3'd1, 3'd0, 3'd0, 3'd0,
          3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0},
        '{3'd5, 3'd0, 3'd4, 3'd0, 3'd6, 3'd0, 3'd7, 3'd0,
          3'd2, 3'd0, 3'd3, 3'd0, 3'd1, 3'd0, 3'd0, 3'd0},
        '{3'd4, 3'd6, 3'd7, 3'd0, 3'd2, 3'd3, 3'd7, 3'd0,
          3'd1, 3'd5, 3'd7, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0}
    };

    typedef enum logic [1:0] {
        KIND_TICK = 2'd0,
        KIND_LOW  = 2'd1,
        KIND_HIGH = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        PH_IDLE         = 2'd0,
        PH_LEADER_SPACE = 2'd1,
        PH_DATA         = 2'd2,
        PH_END          = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        ST_NONE       = 2'd0,
        ST_ACCEPT     = 2'd1,
        ST_LEADER_REJ = 2'd2,
        ST_GAP_REJ    = 2'd3
    } t_frame_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LEADER_MIN = 3'd0,
        CFG_LEADER_MAX = 3'd1,
        CFG_ONE_THRESH = 3'd2,
        CFG_END_GAP    = 3'd3,
        CFG_CMD_NEXT   = 3'd4,
        CFG_CMD_SLOWER = 3'd5,
        CFG_CMD_FASTER = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic [7:0] leader_min;
        logic [7:0] leader_max;
        logic [7:0] one_thresh;
        logic [7:0] end_gap;
        logic [7:0] cmd_next;
        logic [7:0] cmd_slower;
        logic [7:0] cmd_faster;
    } t_cfg;

    typedef struct packed {
        logic       apply;
        logic [7:0] code;
    } t_cmd_evt;

    typedef struct packed {
        t_frame_status status;
        logic [7:0]    command;
    } t_rx_out;

    typedef struct packed {
        logic [2:0] led;
        logic       aux;
        logic       stepped;
        logic [1:0] pattern;
        logic [7:0] interval;
    } t_seq_out;

endpackage

// ----- src/irlps_rx.sv -----
`timescale 1ns / 1ps

module irlps_rx #(
    parameter int FRAME_BYTES = irlps_pkg::FRAME_BYTES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_go,
    input  logic [1:0]          i_kind,
    input  logic [7:0]          i_duration,
    input  irlps_pkg::t_cfg     i_cfg,
    output irlps_pkg::t_rx_out  o_rx,
    output irlps_pkg::t_cmd_evt o_evt
);

    localparam logic [irlps_pkg::BIT_CNT_W-1:0] LastBit =
        irlps_pkg::BIT_CNT_W'(FRAME_BYTES * 8 - 1);

    irlps_pkg::t_phase                r_phase, n_phase;
    logic [irlps_pkg::BIT_CNT_W-1:0]  r_bits, n_bits;
    logic [7:0]                       r_cmd, n_cmd;
    logic [7:0]                       r_last, n_last;
    irlps_pkg::t_frame_status         status;
    irlps_pkg::t_cmd_evt              evt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= irlps_pkg::PH_IDLE;
            r_bits  <= '0;
            r_cmd   <= '0;
            r_last  <= '0;
        end else begin
            r_phase <= n_phase;
            r_bits  <= n_bits;
            r_cmd   <= n_cmd;
            r_last  <= n_last;
        end
    end

    always_comb begin
        n_phase  = r_phase;
        n_bits   = r_bits;
        n_cmd    = r_cmd;
        n_last   = r_last;
        status   = irlps_pkg::ST_NONE;
        evt      = '0;
        if (i_go) begin
            case (irlps_pkg::t_kind'(i_kind))
                irlps_pkg::KIND_LOW: begin
                    if (r_phase == irlps_pkg::PH_IDLE) begin
                        if (i_duration >= i_cfg.leader_min &&
                            i_duration <= i_cfg.leader_max) begin
                            n_phase = irlps_pkg::PH_LEADER_SPACE;
                            n_bits  = '0;
                            n_cmd   = '0;
                        end else begin
                            status = irlps_pkg::ST_LEADER_REJ;
                        end
                    end
                end
                irlps_pkg::KIND_HIGH: begin
                    unique case (r_phase)
                        irlps_pkg::PH_IDLE: begin
                        end
                        irlps_pkg::PH_LEADER_SPACE: begin
                            n_phase = irlps_pkg::PH_DATA;
                        end
                        irlps_pkg::PH_DATA: begin
                            // only byte 2 is kept
                            if (r_bits[5:3] == 3'd2 && i_duration >= i_cfg.one_thresh) begin
                                n_cmd[r_bits[2:0]] = 1'b1;
                            end
                            if (r_bits >= LastBit) begin
                                n_phase = irlps_pkg::PH_END;
                                n_bits  = '0;
                            end else begin
                                n_bits = r_bits + 1'b1;
                            end
                        end
                        irlps_pkg::PH_END: begin
                            if (i_duration > i_cfg.end_gap) begin
                                n_last    = r_cmd;
                                evt.apply = 1'b1;
                                evt.code  = r_cmd;
                                status    = irlps_pkg::ST_ACCEPT;
                            end else begin
                                status = irlps_pkg::ST_GAP_REJ;
                            end
                            n_phase = irlps_pkg::PH_IDLE;
                        end
                    endcase
                end
                default: begin
                end
            endcase
        end
    end

    assign o_rx.status  = status;
    assign o_rx.command = n_last;
    assign o_evt        = evt;

endmodule

// ----- src/irlps_seq.sv -----
`timescale 1ns / 1ps

module irlps_seq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_go,
    input  logic [1:0]          i_kind,
    input  irlps_pkg::t_cfg     i_cfg,
    input  irlps_pkg::t_cmd_evt i_evt,
    output irlps_pkg::t_seq_out o_seq
);

    logic [7:0] r_tick, n_tick;
    logic [7:0] r_int, n_int;
    logic [1:0] r_pat, n_pat;
    logic [3:0] r_step, n_step;
    logic       r_toggle, n_toggle;
    logic [2:0] r_led, n_led;
    logic       r_aux, n_aux;
    logic       stepped;
    logic [1:0] sel;
    logic [7:0] tick_inc;
    logic [3:0] step_inc;
    logic [1:0] pat_inc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick   <= '0;
            r_int    <= irlps_pkg::INTERVAL_RESET;
            r_pat    <= '0;
            r_step   <= '0;
            r_toggle <= 1'b0;
            r_led    <= irlps_pkg::LED_OFF;
            r_aux    <= 1'b0;
        end else begin
            r_tick   <= n_tick;
            r_int    <= n_int;
            r_pat    <= n_pat;
            r_step   <= n_step;
            r_toggle <= n_toggle;
            r_led    <= n_led;
            r_aux    <= n_aux;
        end
    end

    always_comb begin
        sel      = (r_pat == 2'd3) ? 2'd0 : r_pat;
        tick_inc = r_tick + 8'd1;
        step_inc = r_step + 4'd1;
        pat_inc  = r_pat + 2'd1;
        n_tick   = r_tick;
        n_int    = r_int;
        n_pat    = r_pat;
        n_step   = r_step;
        n_toggle = r_toggle;
        n_led    = r_led;
        n_aux    = r_aux;
        stepped  = 1'b0;
        if (i_go && irlps_pkg::t_kind'(i_kind) == irlps_pkg::KIND_TICK) begin
            if (tick_inc >= r_int) begin
                if (step_inc >= irlps_pkg::PAT_LEN[sel]) begin
                    n_step = '0;
                end else begin
                    n_step = step_inc;
                end
                n_led    = ~irlps_pkg::PAT_TAB[sel][n_step];
                n_aux    = r_toggle;
                n_toggle = ~r_toggle;
                n_tick   = '0;
                stepped  = 1'b1;
            end else begin
                n_tick = tick_inc;
            end
        end
        if (i_evt.apply) begin
            if (i_evt.code == i_cfg.cmd_next) begin
                n_pat = (pat_inc >= 2'd3) ? 2'd0 : pat_inc;
            end else if (i_evt.code == i_cfg.cmd_slower) begin
                if (r_int < irlps_pkg::INTERVAL_LIMIT) begin
                    n_int = r_int + irlps_pkg::INTERVAL_STEP;
                end
            end else if (i_evt.code == i_cfg.cmd_faster) begin
                if (r_int > irlps_pkg::INTERVAL_STEP) begin
                    n_int = r_int - irlps_pkg::INTERVAL_STEP;
                end
            end
        end
    end

    assign o_seq.led      = n_led;
    assign o_seq.aux      = n_aux;
    assign o_seq.stepped  = stepped;
    assign o_seq.pattern  = n_pat;
    assign o_seq.interval = n_int;

endmodule

// ----- src/ir_remote_led_pattern_sequencer.sv -----
`timescale 1ns / 1ps
// Throughput: one transaction per cycle unless i_stall holds a valid result;
// an input register and a result register separate the channels, and frame
// decode plus pattern update sit between them.
// Reset (synchronous, active low): decoder idle, LED register off (pins are not
// reset), interval 50, config registers at defaults, pipeline stages empty.
module ir_remote_led_pattern_sequencer #(
    parameter int FRAME_BYTES = irlps_pkg::FRAME_BYTES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [1:0]                      i_kind,
    input  logic [7:0]                      i_duration,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [2:0]                      o_led_pins,
    output logic                            o_aux_pin,
    output logic                            o_step_taken,
    output logic [1:0]                      o_frame_status,
    output logic [7:0]                      o_command,
    output logic [1:0]                      o_pattern_index,
    output logic [7:0]                      o_step_interval,
    input  logic                            i_cfg_we,
    input  logic [irlps_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [irlps_pkg::CFG_W-1:0]     i_cfg_data
);

    irlps_pkg::t_cfg      r_cfg;
    logic                 r_in_vld;
    logic [1:0]           r_kind;
    logic [7:0]           r_dur;
    logic                 r_out_vld;
    logic                 advance;
    logic                 go;
    irlps_pkg::t_rx_out   rx_out;
    irlps_pkg::t_cmd_evt  evt;
    irlps_pkg::t_seq_out  seq_out;

    assign advance = !r_out_vld || !i_stall;
    assign go      = r_in_vld && advance;
    assign o_stall = r_in_vld && !advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.leader_min <= irlps_pkg::LEADER_MIN_RST;
            r_cfg.leader_max <= irlps_pkg::LEADER_MAX_RST;
            r_cfg.one_thresh <= irlps_pkg::ONE_THRESH_RST;
            r_cfg.end_gap    <= irlps_pkg::END_GAP_RST;
            r_cfg.cmd_next   <= irlps_pkg::CMD_NEXT_RST;
            r_cfg.cmd_slower <= irlps_pkg::CMD_SLOWER_RST;
            r_cfg.cmd_faster <= irlps_pkg::CMD_FASTER_RST;
        end else if (i_cfg_we) begin
            unique case (irlps_pkg::t_cfg_idx'(i_cfg_idx))
                irlps_pkg::CFG_LEADER_MIN: r_cfg.leader_min <= i_cfg_data;
                irlps_pkg::CFG_LEADER_MAX: r_cfg.leader_max <= i_cfg_data;
                irlps_pkg::CFG_ONE_THRESH: r_cfg.one_thresh <= i_cfg_data;
                irlps_pkg::CFG_END_GAP:    r_cfg.end_gap    <= i_cfg_data;
                irlps_pkg::CFG_CMD_NEXT:   r_cfg.cmd_next   <= i_cfg_data;
                irlps_pkg::CFG_CMD_SLOWER: r_cfg.cmd_slower <= i_cfg_data;
                irlps_pkg::CFG_CMD_FASTER: r_cfg.cmd_faster <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (!o_stall) begin
            r_in_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_kind <= i_kind;
            r_dur  <= i_duration;
        end
    end

    irlps_rx #(
        .FRAME_BYTES(FRAME_BYTES)
    ) u_rx (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_go       (go),
        .i_kind     (r_kind),
        .i_duration (r_dur),
        .i_cfg      (r_cfg),
        .o_rx       (rx_out),
        .o_evt      (evt)
    );

    irlps_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (go),
        .i_kind  (r_kind),
        .i_cfg   (r_cfg),
        .i_evt   (evt),
        .o_seq   (seq_out)
    );

    // result stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (go) begin
            o_led_pins      <= seq_out.led;
            o_aux_pin       <= seq_out.aux;
            o_step_taken    <= seq_out.stepped;
            o_frame_status  <= rx_out.status;
            o_command       <= rx_out.command;
            o_pattern_index <= seq_out.pattern;
            o_step_interval <= seq_out.interval;
        end
    end

    assign o_valid = r_out_vld;

endmodule
